>>> design/csdo_pkg.sv
// ----------------------------------------------------------------------------
// csdo_pkg
// Shared constants, codes and controller/datapath signal groups for the
// CANopen SDO client.
// ----------------------------------------------------------------------------
package csdo_pkg;

    // Default buffer size in bytes
    localparam int BUF_BYTES_DEF = 256;

    // Configuration port
    localparam int          PADDR_W       = 3;
    localparam logic [2:0]  REG_NODE_ADDR = 3'd0;
    localparam logic [6:0]  NODE_ID_RST   = 7'd1;

    // CAN identifiers
    localparam logic [10:0] TX_ID_BASE = 11'h600;
    localparam logic [10:0] RX_ID_BASE = 11'h580;

    // Request function codes
    localparam logic [2:0] FN_POLL  = 3'd0;
    localparam logic [2:0] FN_WRITE = 3'd1;
    localparam logic [2:0] FN_READ  = 3'd2;
    localparam logic [2:0] FN_LOAD  = 3'd3;
    localparam logic [2:0] FN_PEEK  = 3'd4;

    // SDO command specifiers seen in replies
    localparam logic [2:0] CS_UP_SEG   = 3'd0;
    localparam logic [2:0] CS_DN_SEG   = 3'd1;
    localparam logic [2:0] CS_UP_INIT  = 3'd2;
    localparam logic [2:0] CS_DN_INIT  = 3'd3;
    localparam logic [2:0] CS_ABORT    = 3'd4;

    // Request command bytes
    localparam logic [7:0] CMD_DN_EXP0 = 8'h22;
    localparam logic [7:0] CMD_DN_SEG  = 8'h21;
    localparam logic [7:0] CMD_UP_INIT = 8'h40;

    // Controller to datapath commands
    typedef struct packed {
        logic       accept;
        logic       eval;
        logic       copy_we;
        logic       rd_capture;
        logic [2:0] idx;
    } cmd_t;

    // Datapath to controller status: byte copy plan of the current item
    typedef struct packed {
        logic       to_buf;
        logic [2:0] cnt;
    } sts_t;

endpackage

>>> design/csdo_if.sv
// ----------------------------------------------------------------------------
// csdo_in_if / csdo_out_if
// Valid/ready channels carrying one request item and one result item.
// ----------------------------------------------------------------------------
interface csdo_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  func;
    logic [15:0] index;
    logic [7:0]  subindex;
    logic [7:0]  length;
    logic [7:0]  byte_addr;
    logic [7:0]  byte_value;
    logic        rx_valid;
    logic [10:0] rx_cob_id;
    logic [63:0] rx_frame;
    logic        tx_ok;

    modport source (
        output valid, func, index, subindex, length, byte_addr, byte_value,
               rx_valid, rx_cob_id, rx_frame, tx_ok,
        input  ready
    );
    modport sink (
        input  valid, func, index, subindex, length, byte_addr, byte_value,
               rx_valid, rx_cob_id, rx_frame, tx_ok,
        output ready
    );
endinterface

interface csdo_out_if;
    logic        valid;
    logic        ready;
    logic        tx_valid;
    logic [10:0] tx_cob_id;
    logic [63:0] tx_frame;
    logic        accepted;
    logic        idle;
    logic        had_error;
    logic [31:0] abort_word;
    logic [8:0]  bytes_done;
    logic [7:0]  data_byte;

    modport source (
        output valid, tx_valid, tx_cob_id, tx_frame, accepted, idle, had_error,
               abort_word, bytes_done, data_byte,
        input  ready
    );
    modport sink (
        input  valid, tx_valid, tx_cob_id, tx_frame, accepted, idle, had_error,
               abort_word, bytes_done, data_byte,
        output ready
    );
endinterface

>>> design/csdo_ctrl.sv
// ----------------------------------------------------------------------------
// csdo_ctrl
// Item sequencer: accept, evaluate, byte copy loop, result hold.
// ----------------------------------------------------------------------------
module csdo_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  csdo_pkg::sts_t    sts,
    output csdo_pkg::cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_ROUTE,
        S_WRITE,
        S_RADDR,
        S_RDATA,
        S_OUT
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] i_reg, i_next;
    logic       in_ready_reg, in_ready_next;
    logic       out_valid_reg, out_valid_next;
    logic       last_byte;

    assign last_byte = (i_reg == sts.cnt - 3'd1);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready_reg)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                state_next = S_ROUTE;
            end
            S_ROUTE:
            begin
                i_next = 3'd0;
                if (sts.cnt == 3'd0)
                begin
                    state_next = S_OUT;
                end
                else if (sts.to_buf)
                begin
                    state_next = S_WRITE;
                end
                else
                begin
                    state_next = S_RADDR;
                end
            end
            S_WRITE:
            begin
                if (last_byte)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    i_next = i_reg + 3'd1;
                end
            end
            S_RADDR:
            begin
                state_next = S_RDATA;
            end
            S_RDATA:
            begin
                if (last_byte)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    i_next     = i_reg + 3'd1;
                    state_next = S_RADDR;
                end
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        in_ready_next  = (state_next == S_IDLE);
        out_valid_next = (state_next == S_OUT);
    end

    // Hold state and handshake outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            i_reg         <= 3'd0;
            in_ready_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            i_reg         <= i_next;
            in_ready_reg  <= in_ready_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = in_ready_reg;
    assign out_valid = out_valid_reg;

    // Commands to the datapath
    always_comb
    begin
        cmd            = '0;
        cmd.accept     = (state_reg == S_IDLE) && in_valid && in_ready_reg;
        cmd.eval       = (state_reg == S_EVAL);
        cmd.copy_we    = (state_reg == S_WRITE);
        cmd.rd_capture = (state_reg == S_RDATA);
        cmd.idx        = i_reg;
    end

endmodule

>>> design/csdo_dp.sv
// ----------------------------------------------------------------------------
// csdo_dp
// SDO transfer state, frame build/parse and the byte buffer memory.
// ----------------------------------------------------------------------------
module csdo_dp #(
    parameter int BUF_BYTES = csdo_pkg::BUF_BYTES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  csdo_pkg::cmd_t    cmd,
    output csdo_pkg::sts_t    sts,
    input  logic              node_we,
    input  logic [6:0]        node_wdata,
    output logic [6:0]        node_id,
    input  logic [2:0]        func,
    input  logic [15:0]       index,
    input  logic [7:0]        subindex,
    input  logic [7:0]        length,
    input  logic [7:0]        byte_addr,
    input  logic [7:0]        byte_value,
    input  logic              rx_valid,
    input  logic [10:0]       rx_cob_id,
    input  logic [63:0]       rx_frame,
    input  logic              tx_ok,
    output logic              tx_valid,
    output logic [10:0]       tx_cob_id,
    output logic [63:0]       tx_frame,
    output logic              accepted,
    output logic              idle,
    output logic              had_error,
    output logic [31:0]       abort_word,
    output logic [8:0]        bytes_done,
    output logic [7:0]        data_byte
);

    localparam int AW  = $clog2(BUF_BYTES);
    localparam int CW  = ($clog2(BUF_BYTES + 1) > 9) ? $clog2(BUF_BYTES + 1) : 9;
    localparam int CW1 = CW + 1;

    typedef enum logic [3:0] {
        PH_INIT    = 4'd0,
        PH_IDLE    = 4'd1,
        PH_WR_TX   = 4'd2,
        PH_WR_RX   = 4'd3,
        PH_WSEG_TX = 4'd4,
        PH_WSEG_RX = 4'd5,
        PH_RD_TX   = 4'd6,
        PH_RD_RX   = 4'd7,
        PH_RSEG_TX = 4'd8,
        PH_RSEG_RX = 4'd9,
        PH_DONE    = 4'd10,
        PH_ERROR   = 4'd11
    } phase_t;

    function automatic logic [63:0] hdr(input logic [7:0] cb, input logic [15:0] ix,
                                        input logic [7:0] sb);
        hdr = {32'd0, sb, ix, cb};
    endfunction

    // Item registers
    logic [2:0]  func_reg;
    logic [15:0] idx_reg;
    logic [7:0]  sub_reg, len_reg, addr_reg, val_reg;
    logic        rx_reg, ok_reg;
    logic [63:0] rxf_reg;

    // Transfer state
    logic [6:0]  node_reg;
    phase_t      phase_reg, phase_next;
    logic [15:0] oidx_reg, oidx_next;
    logic [7:0]  osub_reg, osub_next;
    logic [31:0] total_reg, total_next;
    logic [CW-1:0] done_reg, done_next;
    logic        tog_reg, tog_next;
    logic [31:0] abort_reg, abort_next;
    logic        err_reg, err_next;

    // Result and copy plan
    logic        txv_reg, txv_next;
    logic [63:0] txf_reg, txf_next;
    logic        acc_reg, acc_next;
    logic [7:0]  dbyte_reg;
    logic        to_buf_reg, to_buf_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [CW1-1:0] base_reg, base_next;
    logic [2:0]  off_reg, off_next;
    logic        use_item_reg, use_item_next;

    // Buffer memory
    logic [7:0]  buf_mem [BUF_BYTES];
    logic [7:0]  rd_data_reg;

    // Reply decode
    logic [7:0]  b0;
    logic [2:0]  cs;
    logic        tg, sbit, hdr_ok;
    logic [31:0] diff;
    logic [2:0]  size;
    logic [CW1-1:0] seg_end;

    assign b0     = rxf_reg[7:0];
    assign cs     = b0[7:5];
    assign tg     = b0[4];
    assign sbit   = b0[0];
    assign hdr_ok = (rxf_reg[23:8] == oidx_reg) && (rxf_reg[31:24] == osub_reg);
    assign diff   = total_reg - 32'(done_reg);

    // Evaluate one item against the transfer state
    always_comb
    begin
        phase_next    = phase_reg;
        oidx_next     = oidx_reg;
        osub_next     = osub_reg;
        total_next    = total_reg;
        done_next     = done_reg;
        tog_next      = tog_reg;
        abort_next    = abort_reg;
        err_next      = err_reg;
        txv_next      = 1'b0;
        txf_next      = 64'd0;
        acc_next      = 1'b0;
        to_buf_next   = 1'b0;
        cnt_next      = 3'd0;
        base_next     = '0;
        off_next      = 3'd0;
        use_item_next = 1'b0;
        size          = 3'd0;
        seg_end       = '0;
        case (func_reg)
            csdo_pkg::FN_POLL:
            begin
                case (phase_reg)
                    PH_INIT:
                    begin
                        phase_next = PH_IDLE;
                    end
                    PH_IDLE:
                    begin
                        phase_next = PH_IDLE;
                    end
                    PH_WR_TX:
                    begin
                        if (total_reg == 32'd0)
                        begin
                            txf_next  = hdr(csdo_pkg::CMD_DN_EXP0, oidx_reg, osub_reg);
                            done_next = '0;
                        end
                        else if (total_reg <= 32'd4)
                        begin
                            txf_next  = hdr({3'b001, 1'b0, 2'(3'd4 - total_reg[2:0]), 2'b11},
                                            oidx_reg, osub_reg);
                            cnt_next  = total_reg[2:0];
                            off_next  = 3'd4;
                            done_next = CW'(total_reg[2:0]);
                        end
                        else
                        begin
                            txf_next  = hdr(csdo_pkg::CMD_DN_SEG, oidx_reg, osub_reg)
                                        | {total_reg, 32'd0};
                            done_next = '0;
                        end
                        txv_next   = ok_reg;
                        phase_next = ok_reg ? PH_WR_RX : PH_ERROR;
                    end
                    PH_WR_RX:
                    begin
                        if (rx_reg)
                        begin
                            if (hdr_ok && cs == csdo_pkg::CS_DN_INIT)
                            begin
                                if (32'(done_reg) == total_reg)
                                begin
                                    phase_next = PH_DONE;
                                end
                                else
                                begin
                                    phase_next = PH_WSEG_TX;
                                    tog_next   = 1'b0;
                                end
                            end
                            else
                            begin
                                if (cs == csdo_pkg::CS_ABORT)
                                begin
                                    abort_next = rxf_reg[63:32];
                                end
                                phase_next = PH_ERROR;
                            end
                        end
                    end
                    PH_WSEG_TX:
                    begin
                        if (total_reg > 32'(done_reg))
                        begin
                            size = (diff > 32'd7) ? 3'd7 : diff[2:0];
                        end
                        cnt_next   = size;
                        base_next  = CW1'(done_reg);
                        off_next   = 3'd1;
                        done_next  = done_reg + CW'(size);
                        txf_next   = {56'd0, 3'b000, tog_reg, 3'd7 - size, size != 3'd7};
                        txv_next   = ok_reg;
                        phase_next = ok_reg ? PH_WSEG_RX : PH_ERROR;
                    end
                    PH_WSEG_RX:
                    begin
                        if (rx_reg)
                        begin
                            if (cs == csdo_pkg::CS_DN_SEG && tg == tog_reg)
                            begin
                                if (32'(done_reg) == total_reg)
                                begin
                                    phase_next = PH_DONE;
                                end
                                else
                                begin
                                    phase_next = PH_WSEG_TX;
                                    tog_next   = ~tog_reg;
                                end
                            end
                            else
                            begin
                                if (cs == csdo_pkg::CS_ABORT)
                                begin
                                    abort_next = rxf_reg[63:32];
                                end
                                phase_next = PH_ERROR;
                            end
                        end
                    end
                    PH_RD_TX:
                    begin
                        txf_next   = hdr(csdo_pkg::CMD_UP_INIT, oidx_reg, osub_reg);
                        txv_next   = ok_reg;
                        phase_next = ok_reg ? PH_RD_RX : PH_ERROR;
                    end
                    PH_RD_RX:
                    begin
                        if (rx_reg)
                        begin
                            if (hdr_ok && cs == csdo_pkg::CS_UP_INIT)
                            begin
                                if (b0[1])
                                begin
                                    size        = sbit ? 3'd4 - {1'b0, b0[3:2]} : 3'd4;
                                    to_buf_next = 1'b1;
                                    cnt_next    = size;
                                    off_next    = 3'd4;
                                    done_next   = CW'(size);
                                    phase_next  = PH_DONE;
                                end
                                else
                                begin
                                    total_next = sbit ? rxf_reg[63:32] : 32'hFFFF_FFFF;
                                    phase_next = PH_RSEG_TX;
                                    done_next  = '0;
                                    tog_next   = 1'b0;
                                end
                            end
                            else
                            begin
                                if (cs == csdo_pkg::CS_ABORT)
                                begin
                                    abort_next = rxf_reg[63:32];
                                end
                                phase_next = PH_ERROR;
                            end
                        end
                    end
                    PH_RSEG_TX:
                    begin
                        txf_next   = {56'd0, 3'b011, tog_reg, 4'd0};
                        txv_next   = ok_reg;
                        phase_next = ok_reg ? PH_RSEG_RX : PH_ERROR;
                    end
                    PH_RSEG_RX:
                    begin
                        if (rx_reg)
                        begin
                            if (cs == csdo_pkg::CS_UP_SEG && tg == tog_reg)
                            begin
                                size    = sbit ? 3'd7 - b0[3:1] : 3'd7;
                                seg_end = CW1'(done_reg) + CW1'(size);
                                if (seg_end > CW1'(BUF_BYTES))
                                begin
                                    phase_next = PH_ERROR;
                                end
                                else
                                begin
                                    to_buf_next = 1'b1;
                                    cnt_next    = size;
                                    base_next   = CW1'(done_reg);
                                    off_next    = 3'd1;
                                    done_next   = seg_end[CW-1:0];
                                    if (sbit)
                                    begin
                                        phase_next = PH_DONE;
                                    end
                                    else
                                    begin
                                        tog_next   = ~tog_reg;
                                        phase_next = PH_RSEG_TX;
                                    end
                                end
                            end
                            else
                            begin
                                if (cs == csdo_pkg::CS_ABORT)
                                begin
                                    abort_next = rxf_reg[63:32];
                                end
                                phase_next = PH_ERROR;
                            end
                        end
                    end
                    PH_DONE:
                    begin
                        phase_next = PH_IDLE;
                    end
                    default:
                    begin
                        err_next   = 1'b1;
                        phase_next = PH_INIT;
                    end
                endcase
            end
            csdo_pkg::FN_WRITE, csdo_pkg::FN_READ:
            begin
                if (phase_reg == PH_IDLE && idx_reg != 16'd0)
                begin
                    acc_next   = 1'b1;
                    err_next   = 1'b0;
                    oidx_next  = idx_reg;
                    osub_next  = sub_reg;
                    total_next = 32'(len_reg);
                    if (func_reg == csdo_pkg::FN_WRITE)
                    begin
                        abort_next = 32'd0;
                        phase_next = PH_WR_TX;
                    end
                    else
                    begin
                        phase_next = PH_RD_TX;
                    end
                end
            end
            csdo_pkg::FN_LOAD:
            begin
                to_buf_next   = 1'b1;
                cnt_next      = 3'd1;
                base_next     = CW1'(addr_reg);
                use_item_next = 1'b1;
            end
            csdo_pkg::FN_PEEK:
            begin
                cnt_next      = 3'd1;
                base_next     = CW1'(addr_reg);
                use_item_next = 1'b1;
            end
            default:
            begin
                cnt_next = 3'd0;
            end
        endcase
    end

    // Byte copy addressing
    logic [CW1-1:0] a_full;
    logic           a_in;
    logic [2:0]     pos;
    logic [7:0]     wr_byte, rd_byte;

    assign a_full  = base_reg + CW1'(cmd.idx);
    assign a_in    = (a_full < CW1'(BUF_BYTES));
    assign pos     = off_reg + cmd.idx;
    assign wr_byte = use_item_reg ? val_reg : rxf_reg[{pos, 3'b000} +: 8];
    assign rd_byte = a_in ? rd_data_reg : 8'd0;

    // Buffer write and registered read
    always_ff @(posedge clk)
    begin
        if (cmd.copy_we && a_in)
        begin
            buf_mem[a_full[AW-1:0]] <= wr_byte;
        end
        rd_data_reg <= buf_mem[a_full[AW-1:0]];
    end

    // Capture the item
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            func_reg <= func;
            idx_reg  <= index;
            sub_reg  <= subindex;
            len_reg  <= length;
            addr_reg <= byte_addr;
            val_reg  <= byte_value;
            rx_reg   <= rx_valid && (rx_cob_id == csdo_pkg::RX_ID_BASE + 11'(node_reg));
            rxf_reg  <= rx_frame;
            ok_reg   <= tx_ok;
        end
    end

    // Result payload: frame and peeked byte
    always_ff @(posedge clk)
    begin
        if (cmd.eval)
        begin
            txf_reg   <= txf_next;
            dbyte_reg <= 8'd0;
        end
        else if (cmd.rd_capture)
        begin
            if (use_item_reg)
            begin
                dbyte_reg <= rd_byte;
            end
            else
            begin
                txf_reg[{pos, 3'b000} +: 8] <= rd_byte;
            end
        end
    end

    // Transfer state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_reg     <= csdo_pkg::NODE_ID_RST;
            phase_reg    <= PH_INIT;
            oidx_reg     <= 16'd0;
            osub_reg     <= 8'd0;
            total_reg    <= 32'd0;
            done_reg     <= '0;
            tog_reg      <= 1'b0;
            abort_reg    <= 32'd0;
            err_reg      <= 1'b0;
            txv_reg      <= 1'b0;
            acc_reg      <= 1'b0;
            to_buf_reg   <= 1'b0;
            cnt_reg      <= 3'd0;
            base_reg     <= '0;
            off_reg      <= 3'd0;
            use_item_reg <= 1'b0;
        end
        else
        begin
            if (node_we)
            begin
                node_reg <= node_wdata;
            end
            if (cmd.eval)
            begin
                phase_reg    <= phase_next;
                oidx_reg     <= oidx_next;
                osub_reg     <= osub_next;
                total_reg    <= total_next;
                done_reg     <= done_next;
                tog_reg      <= tog_next;
                abort_reg    <= abort_next;
                err_reg      <= err_next;
                txv_reg      <= txv_next;
                acc_reg      <= acc_next;
                to_buf_reg   <= to_buf_next;
                cnt_reg      <= cnt_next;
                base_reg     <= base_next;
                off_reg      <= off_next;
                use_item_reg <= use_item_next;
            end
        end
    end

    assign sts.to_buf = to_buf_reg;
    assign sts.cnt    = cnt_reg;

    assign node_id    = node_reg;
    assign tx_valid   = txv_reg;
    assign tx_cob_id  = txv_reg ? csdo_pkg::TX_ID_BASE + 11'(node_reg) : 11'd0;
    assign tx_frame   = txv_reg ? txf_reg : 64'd0;
    assign accepted   = acc_reg;
    assign idle       = (phase_reg == PH_IDLE);
    assign had_error  = err_reg;
    assign abort_word = abort_reg;
    assign bytes_done = done_reg[8:0];
    assign data_byte  = dbyte_reg;

endmodule

>>> design/canopen_sdo_client_unit.sv
// ----------------------------------------------------------------------------
// canopen_sdo_client_unit
// CANopen SDO client: expedited and segmented download/upload, one request
// item in, one result item out.
//
//   channel | dir | handshake      | content
//   --------+-----+----------------+----------------------------------------
//   in_ch   | in  | valid/ready    | func, object, buffer byte, rx frame
//   out_ch  | out | valid/ready    | tx frame, status, abort code, byte
//   apb     | in  | psel/penable   | node_id at address 0
//
// One item at a time. After the input transfer the item is evaluated and
// routed; the byte copy loop then writes each buffer byte, or addresses and
// captures each buffer byte read (registered memory read), over the single
// buffer port. The result holds until taken; a new item is taken the
// cycle after. Reset is asynchronous, active low; the buffer is not cleared.
// ----------------------------------------------------------------------------
module canopen_sdo_client_unit #(
    parameter int BUF_BYTES = csdo_pkg::BUF_BYTES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    csdo_in_if.sink                      in_ch,
    csdo_out_if.source                   out_ch,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [csdo_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    csdo_pkg::cmd_t cmd;
    csdo_pkg::sts_t sts;
    logic           node_we;
    logic [6:0]     node_id;

    // Register access
    assign pready  = 1'b1;
    assign node_we = psel && penable && pwrite && (paddr == csdo_pkg::REG_NODE_ADDR);
    assign prdata  = (paddr == csdo_pkg::REG_NODE_ADDR) ? 32'(node_id) : 32'd0;

    csdo_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    csdo_dp #(
        .BUF_BYTES (BUF_BYTES)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .node_we    (node_we),
        .node_wdata (pwdata[6:0]),
        .node_id    (node_id),
        .func       (in_ch.func),
        .index      (in_ch.index),
        .subindex   (in_ch.subindex),
        .length     (in_ch.length),
        .byte_addr  (in_ch.byte_addr),
        .byte_value (in_ch.byte_value),
        .rx_valid   (in_ch.rx_valid),
        .rx_cob_id  (in_ch.rx_cob_id),
        .rx_frame   (in_ch.rx_frame),
        .tx_ok      (in_ch.tx_ok),
        .tx_valid   (out_ch.tx_valid),
        .tx_cob_id  (out_ch.tx_cob_id),
        .tx_frame   (out_ch.tx_frame),
        .accepted   (out_ch.accepted),
        .idle       (out_ch.idle),
        .had_error  (out_ch.had_error),
        .abort_word (out_ch.abort_word),
        .bytes_done (out_ch.bytes_done),
        .data_byte  (out_ch.data_byte)
    );

    // Never take an item while a result is pending
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ch.ready && out_ch.valid))
        else $error("input ready while result pending");

    // A result never follows its item in the very next cycle
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> !out_ch.valid)
        else $error("result too early");

    // A taken start leaves the machine busy
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.accepted) |-> !out_ch.idle)
        else $error("accepted start reports idle");

endmodule

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for canopen_sdo_client_unit. A queue of request items,
// filled by a generator that tracks the client's transfer state, feeds a
// valid/ready driver. Every item is run through a behavioral model of the SDO
// client when it is queued. A monitor compares each result transfer, field
// by field, with the oldest predicted result. The node number is changed over
// APB between drained phases.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MEM_BYTES = csdo_pkg::BUF_BYTES_DEF;
    localparam int QUIET_LIMIT = 6000;
    localparam int DRAIN_CYCLES = 30;
    localparam int LONG_HOLD = 400;

    // Request command bits not held in the package
    localparam logic [7:0] CMD_DN_EXP     = 8'h23;
    localparam logic [2:0] CCS_UP_SEG_REQ = 3'd3;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_WR_TX, S_WR_RX, S_WSEG_TX, S_WSEG_RX,
        S_RD_TX, S_RD_RX, S_RSEG_TX, S_RSEG_RX, S_DONE, S_ERROR
    } sdo_phase_e;

    typedef struct packed {
        logic [2:0]  func;
        logic [15:0] index;
        logic [7:0]  subindex;
        logic [7:0]  length;
        logic [7:0]  byte_addr;
        logic [7:0]  byte_value;
        logic        rx_valid;
        logic [10:0] rx_cob_id;
        logic [63:0] rx_frame;
        logic        tx_ok;
    } sdo_req_t;

    typedef struct packed {
        logic        tx_valid;
        logic [10:0] tx_cob_id;
        logic [63:0] tx_frame;
        logic        accepted;
        logic        idle;
        logic        had_error;
        logic [31:0] abort_word;
        logic [8:0]  bytes_done;
        logic [7:0]  data_byte;
    } sdo_rsp_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [csdo_pkg::PADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    csdo_in_if  in_ch ();
    csdo_out_if out_ch ();

    canopen_sdo_client_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch.sink),
        .out_ch  (out_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Model state of the client
    sdo_phase_e  ph;
    logic [6:0]  node;
    logic [15:0] obj_idx;
    logic [7:0]  obj_sub;
    logic [31:0] tot_len;
    int unsigned done_cnt;
    logic        toggle_b;
    logic [31:0] abort_reg;
    logic        err_flag;
    logic [7:0]  sdo_mem [MEM_BYTES];
    bit          mem_set [MEM_BYTES];
    logic        tx_hit;
    logic [63:0] tx_word;

    // Generator steering
    bit          read_exp;
    bit          long_read;
    int          n_items;
    bit          calm;

    sdo_req_t    req_todo_q [$];
    sdo_rsp_t    status_due_q [$];
    int          errors;
    int          out_count;
    bit          in_fire;
    int          quiet_cycles;

    // Clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic [7:0] mem_rd(input int unsigned a);
        return (a < MEM_BYTES) ? sdo_mem[a] : 8'h00;
    endfunction

    task automatic mem_wr(input int unsigned a, input logic [7:0] v);
        if (a < MEM_BYTES)
        begin
            sdo_mem[a] = v;
            mem_set[a] = 1'b1;
        end
    endtask

    function automatic logic [63:0] header(input logic [7:0] cmd);
        return {32'h0, obj_sub, obj_idx, cmd};
    endfunction

    task automatic xmit(input logic [63:0] fr, input bit ok, input sdo_phase_e nxt);
        if (ok)
        begin
            tx_hit = 1'b1;
            tx_word = fr;
            ph = nxt;
        end
        else
            ph = S_ERROR;
    endtask

    task automatic take_fault(input logic [63:0] f);
        if (f[7:5] == csdo_pkg::CS_ABORT)
            abort_reg = f[63:32];
        ph = S_ERROR;
    endtask

    // Advance the client model by one request item
    task automatic sdo_client_step(input sdo_req_t r, output sdo_rsp_t e);
        logic [63:0] f;
        logic [63:0] fr;
        logic [7:0]  b0;
        bit          rx;
        bit          hdr_ok;
        int unsigned seg_len;
        int unsigned i;
        e = '0;
        tx_hit = 1'b0;
        tx_word = '0;
        f = r.rx_frame;
        b0 = f[7:0];
        rx = r.rx_valid && (r.rx_cob_id == csdo_pkg::RX_ID_BASE + 11'(node));
        hdr_ok = (f[23:8] == obj_idx) && (f[31:24] == obj_sub);
        case (r.func)
            csdo_pkg::FN_POLL:
            begin
                case (ph)
                    S_INIT: ph = S_IDLE;
                    S_IDLE: ;
                    S_WR_TX:
                    begin
                        if (tot_len == 0)
                        begin
                            fr = header(csdo_pkg::CMD_DN_EXP0);
                            done_cnt = 0;
                        end
                        else if (tot_len <= 4)
                        begin
                            fr = header(CMD_DN_EXP | 8'((4 - tot_len) << 2));
                            for (i = 0; i < tot_len; i++)
                                fr |= 64'(mem_rd(i)) << (8 * (4 + i));
                            done_cnt = tot_len;
                        end
                        else
                        begin
                            fr = header(csdo_pkg::CMD_DN_SEG) | (64'(tot_len) << 32);
                            done_cnt = 0;
                        end
                        xmit(fr, r.tx_ok, S_WR_RX);
                    end
                    S_WR_RX:
                    begin
                        if (rx)
                        begin
                            if (hdr_ok && b0[7:5] == csdo_pkg::CS_DN_INIT)
                            begin
                                if (done_cnt == tot_len)
                                    ph = S_DONE;
                                else
                                begin
                                    ph = S_WSEG_TX;
                                    toggle_b = 1'b0;
                                end
                            end
                            else
                                take_fault(f);
                        end
                    end
                    S_WSEG_TX:
                    begin
                        seg_len = (tot_len > done_cnt) ? tot_len - done_cnt : 0;
                        if (seg_len > 7)
                            seg_len = 7;
                        fr = '0;
                        for (i = 0; i < seg_len; i++)
                            fr |= 64'(mem_rd(done_cnt + i)) << (8 * (1 + i));
                        done_cnt += seg_len;
                        fr |= 64'({toggle_b, 3'(7 - seg_len), 1'(seg_len != 7)});
                        xmit(fr, r.tx_ok, S_WSEG_RX);
                    end
                    S_WSEG_RX:
                    begin
                        if (rx)
                        begin
                            if (b0[7:5] == csdo_pkg::CS_DN_SEG && b0[4] == toggle_b)
                            begin
                                if (done_cnt == tot_len)
                                    ph = S_DONE;
                                else
                                begin
                                    ph = S_WSEG_TX;
                                    toggle_b = ~toggle_b;
                                end
                            end
                            else
                                take_fault(f);
                        end
                    end
                    S_RD_TX: xmit(header(csdo_pkg::CMD_UP_INIT), r.tx_ok, S_RD_RX);
                    S_RD_RX:
                    begin
                        if (rx)
                        begin
                            if (hdr_ok && b0[7:5] == csdo_pkg::CS_UP_INIT)
                            begin
                                if (b0[1])
                                begin
                                    seg_len = b0[0] ? 4 - b0[3:2] : 4;
                                    for (i = 0; i < seg_len; i++)
                                        mem_wr(i, f[8 * (4 + i) +: 8]);
                                    done_cnt = seg_len;
                                    ph = S_DONE;
                                end
                                else
                                begin
                                    tot_len = b0[0] ? f[63:32] : 32'hFFFF_FFFF;
                                    ph = S_RSEG_TX;
                                    done_cnt = 0;
                                    toggle_b = 1'b0;
                                end
                            end
                            else
                                take_fault(f);
                        end
                    end
                    S_RSEG_TX:
                        xmit(64'({CCS_UP_SEG_REQ, toggle_b, 4'h0}), r.tx_ok, S_RSEG_RX);
                    S_RSEG_RX:
                    begin
                        if (rx)
                        begin
                            if (b0[7:5] == csdo_pkg::CS_UP_SEG && b0[4] == toggle_b)
                            begin
                                seg_len = b0[0] ? 7 - b0[3:1] : 7;
                                if (done_cnt + seg_len > MEM_BYTES)
                                    ph = S_ERROR;
                                else
                                begin
                                    for (i = 0; i < seg_len; i++)
                                        mem_wr(done_cnt + i, f[8 * (1 + i) +: 8]);
                                    done_cnt += seg_len;
                                    if (b0[0])
                                        ph = S_DONE;
                                    else
                                    begin
                                        toggle_b = ~toggle_b;
                                        ph = S_RSEG_TX;
                                    end
                                end
                            end
                            else
                                take_fault(f);
                        end
                    end
                    S_DONE: ph = S_IDLE;
                    default:
                    begin
                        err_flag = 1'b1;
                        ph = S_INIT;
                    end
                endcase
            end
            csdo_pkg::FN_WRITE, csdo_pkg::FN_READ:
            begin
                if (ph == S_IDLE && r.index != 16'h0)
                begin
                    e.accepted = 1'b1;
                    err_flag = 1'b0;
                    if (r.func == csdo_pkg::FN_WRITE)
                    begin
                        abort_reg = '0;
                        ph = S_WR_TX;
                    end
                    else
                        ph = S_RD_TX;
                    obj_idx = r.index;
                    obj_sub = r.subindex;
                    tot_len = 32'(r.length);
                end
            end
            csdo_pkg::FN_LOAD: mem_wr(r.byte_addr, r.byte_value);
            csdo_pkg::FN_PEEK: e.data_byte = mem_rd(r.byte_addr);
            default: ;
        endcase
        e.tx_valid = tx_hit;
        e.tx_cob_id = tx_hit ? csdo_pkg::TX_ID_BASE + 11'(node) : 11'h0;
        e.tx_frame = tx_word;
        e.idle = (ph == S_IDLE);
        e.had_error = err_flag;
        e.abort_word = abort_reg;
        e.bytes_done = done_cnt[8:0];
    endtask

    // Predict and queue one item
    task automatic queue_req(input sdo_req_t r);
        sdo_rsp_t e;
        sdo_client_step(r, e);
        status_due_q.push_back(e);
        req_todo_q.push_back(r);
        n_items++;
    endtask

    function automatic sdo_req_t rand_req(input logic [2:0] fn);
        sdo_req_t r;
        r.func = fn;
        r.index = 16'($urandom);
        r.subindex = 8'($urandom);
        r.length = 8'($urandom);
        r.byte_addr = 8'($urandom);
        r.byte_value = 8'($urandom);
        r.rx_valid = 1'($urandom);
        r.rx_cob_id = 11'($urandom);
        r.rx_frame = {$urandom, $urandom};
        r.tx_ok = ($urandom_range(0, 14) != 0);
        return r;
    endfunction

    task automatic load_byte(input logic [7:0] a, input logic [7:0] v);
        sdo_req_t r;
        r = rand_req(csdo_pkg::FN_LOAD);
        r.byte_addr = a;
        r.byte_value = v;
        queue_req(r);
    endtask

    // Pick a written buffer position, or load one first
    task automatic peek_byte();
        sdo_req_t r;
        int k;
        r = rand_req(csdo_pkg::FN_PEEK);
        for (k = 0; k < 20 && !mem_set[r.byte_addr]; k++)
            r.byte_addr = 8'($urandom);
        if (!mem_set[r.byte_addr])
            load_byte(r.byte_addr, 8'($urandom));
        queue_req(r);
    endtask

    // Stray item: starts that may be refused, loads, reads, unused codes
    task automatic noise_item();
        sdo_req_t r;
        int k;
        int unsigned i;
        k = $urandom_range(0, 5);
        if (k == 3)
            peek_byte();
        else
        begin
            r = rand_req((k < 2) ? 3'(k + 1) :
                         (k == 2) ? csdo_pkg::FN_LOAD : 3'($urandom_range(5, 7)));
            if ($urandom_range(0, 3) == 0)
                r.index = 16'h0;
            // never start a write whose data was not loaded
            if (r.func == csdo_pkg::FN_WRITE && ph == S_IDLE)
                for (i = 0; i < r.length; i++)
                    if (!mem_set[i])
                        r.index = 16'h0;
            queue_req(r);
        end
    endtask

    // One poll step, with a reply shaped for the current phase
    task automatic poll_once();
        sdo_req_t r;
        logic [63:0] f;
        int k;
        bit last;
        r = rand_req(csdo_pkg::FN_POLL);
        f = r.rx_frame;
        if (ph inside {S_WR_RX, S_WSEG_RX, S_RD_RX, S_RSEG_RX})
        begin
            k = $urandom_range(0, 99);
            r.rx_valid = 1'b1;
            r.rx_cob_id = csdo_pkg::RX_ID_BASE + 11'(node);
            if (k < 84)
            begin
                case (ph)
                    S_WR_RX:
                    begin
                        f[7:0] = {csdo_pkg::CS_DN_INIT, 5'($urandom)};
                        f[31:8] = {obj_sub, obj_idx};
                    end
                    S_WSEG_RX: f[7:0] = {csdo_pkg::CS_DN_SEG, toggle_b, 4'($urandom)};
                    S_RD_RX:
                    begin
                        f[7:0] = {csdo_pkg::CS_UP_INIT, 1'b0, 2'($urandom), read_exp,
                                  1'($urandom)};
                        f[31:8] = {obj_sub, obj_idx};
                    end
                    default:
                    begin
                        last = long_read ? ($urandom_range(0, 39) == 0)
                                         : ($urandom_range(0, 3) == 0);
                        f[7:0] = {csdo_pkg::CS_UP_SEG, toggle_b, 3'($urandom), last};
                    end
                endcase
            end
            else if (k < 88)
                f[7:0] = {csdo_pkg::CS_ABORT, 5'($urandom)};
            else if (k >= 93)
            begin
                if ($urandom_range(0, 1) == 0)
                    r.rx_valid = 1'b0;
                else
                    r.rx_cob_id = 11'($urandom);
            end
        end
        r.rx_frame = f;
        queue_req(r);
    endtask

    // Poll until the client is idle again
    task automatic settle();
        int cap;
        for (cap = 0; ph != S_IDLE && cap < 500; cap++)
            if ($urandom_range(0, 99) < 4)
                noise_item();
            else
                poll_once();
    endtask

    task automatic do_write(input int len);
        sdo_req_t r;
        int i;
        settle();
        for (i = 0; i < len; i++)
            if (!mem_set[i] || $urandom_range(0, 2) == 0)
                load_byte(8'(i), 8'($urandom));
        r = rand_req(csdo_pkg::FN_WRITE);
        r.index = 16'($urandom_range(1, 65535));
        r.length = 8'(len);
        queue_req(r);
        settle();
    endtask

    task automatic do_read(input bit expd, input bit lng);
        sdo_req_t r;
        settle();
        read_exp = expd;
        long_read = lng;
        r = rand_req(csdo_pkg::FN_READ);
        r.index = 16'($urandom_range(1, 65535));
        queue_req(r);
        settle();
    endtask

    task automatic run_mix(input int target);
        int k;
        while (n_items < target)
        begin
            k = $urandom_range(0, 99);
            if (k < 35)
            begin
                k = $urandom_range(0, 99);
                do_write(k < 80 ? $urandom_range(0, 12) :
                         k < 98 ? $urandom_range(13, 40) : $urandom_range(41, 255));
            end
            else if (k < 70)
                do_read($urandom_range(0, 1), $urandom_range(0, 19) == 0);
            else if (k < 80)
                poll_once();
            else
                noise_item();
            settle();
        end
    endtask

    // Let every expected result come back, then let the block go quiet
    task automatic drain();
        while (req_todo_q.size() != 0 || status_due_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_node(input logic [6:0] v);
        @(negedge clk);
        psel = 1'b1;
        pwrite = 1'b1;
        paddr = csdo_pkg::REG_NODE_ADDR;
        pwdata = 32'(v);
        penable = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        node = v;
    endtask

    task automatic chk(input string name, input logic [63:0] e, input logic [63:0] a);
        if (a !== e)
        begin
            errors++;
            $display("%0t: %s expected %h got %h", $realtime, name, e, a);
        end
    endtask

    // Sender: hold an offered item until its transfer, idle in bursts
    int send_gap;
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            send_gap <= 0;
        end
        else if (!in_ch.valid || in_fire)
        begin
            if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                in_ch.valid <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 11) == 0)
            begin
                send_gap <= $urandom_range(0, 10);
                in_ch.valid <= 1'b0;
            end
            else if (req_todo_q.size() != 0)
            begin
                sdo_req_t r;
                r = req_todo_q.pop_front();
                in_ch.valid <= 1'b1;
                in_ch.func <= r.func;
                in_ch.index <= r.index;
                in_ch.subindex <= r.subindex;
                in_ch.length <= r.length;
                in_ch.byte_addr <= r.byte_addr;
                in_ch.byte_value <= r.byte_value;
                in_ch.rx_valid <= r.rx_valid;
                in_ch.rx_cob_id <= r.rx_cob_id;
                in_ch.rx_frame <= r.rx_frame;
                in_ch.tx_ok <= r.tx_ok;
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // Receiver: random stall bursts plus one long hold-off
    int recv_hold;
    bit long_done;
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            recv_hold <= 0;
        end
        else if (!long_done && out_count >= 150)
        begin
            long_done <= 1'b1;
            recv_hold <= LONG_HOLD;
            out_ch.ready <= 1'b0;
        end
        else if (recv_hold > 0)
        begin
            recv_hold <= recv_hold - 1;
            out_ch.ready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 11) == 0)
        begin
            recv_hold <= $urandom_range(0, 10);
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= 1'b1;
    end

    // Monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            in_fire <= in_ch.valid && in_ch.ready;
            if (out_ch.valid && out_ch.ready)
            begin
                out_count <= out_count + 1;
                if (status_due_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: result with nothing expected", $realtime);
                end
                else
                begin
                    sdo_rsp_t e;
                    e = status_due_q.pop_front();
                    chk("tx_valid", e.tx_valid, out_ch.tx_valid);
                    chk("tx_cob_id", e.tx_cob_id, out_ch.tx_cob_id);
                    chk("tx_frame", e.tx_frame, out_ch.tx_frame);
                    chk("accepted", e.accepted, out_ch.accepted);
                    chk("idle", e.idle, out_ch.idle);
                    chk("had_error", e.had_error, out_ch.had_error);
                    chk("abort_word", e.abort_word, out_ch.abort_word);
                    chk("bytes_done", e.bytes_done, out_ch.bytes_done);
                    chk("data_byte", e.data_byte, out_ch.data_byte);
                end
            end
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Stimulus and phases
    initial
    begin
        sdo_req_t r;
        int i;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.func = csdo_pkg::FN_POLL;
        in_ch.index = '0;
        in_ch.subindex = '0;
        in_ch.length = '0;
        in_ch.byte_addr = '0;
        in_ch.byte_value = '0;
        in_ch.rx_valid = 1'b0;
        in_ch.rx_cob_id = '0;
        in_ch.rx_frame = '0;
        in_ch.tx_ok = 1'b0;
        out_ch.ready = 1'b0;
        in_fire = 1'b0;
        errors = 0;
        out_count = 0;
        quiet_cycles = 0;
        long_done = 1'b0;
        calm = 1'b0;
        n_items = 0;
        ph = S_INIT;
        node = csdo_pkg::NODE_ID_RST;
        obj_idx = '0;
        obj_sub = '0;
        tot_len = '0;
        done_cnt = 0;
        toggle_b = 1'b0;
        abort_reg = '0;
        err_flag = 1'b0;
        read_exp = 1'b0;
        long_read = 1'b0;
        for (i = 0; i < MEM_BYTES; i++)
        begin
            sdo_mem[i] = 8'h00;
            mem_set[i] = 1'b0;
        end
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: refused starts, buffer extremes, unused codes, short transfers
        r = rand_req(csdo_pkg::FN_WRITE);
        r.index = 16'hFFFF;
        queue_req(r);
        poll_once();
        load_byte(8'h00, 8'hFF);
        load_byte(8'hFF, 8'h00);
        r = rand_req(csdo_pkg::FN_PEEK);
        r.byte_addr = 8'h00;
        queue_req(r);
        r.byte_addr = 8'hFF;
        queue_req(r);
        for (i = 5; i < 8; i++)
            queue_req(rand_req(3'(i)));
        r = rand_req(csdo_pkg::FN_READ);
        r.index = 16'h0;
        queue_req(r);
        do_write(0);
        do_write(4);
        do_write(5);
        do_read(1'b1, 1'b0);
        do_read(1'b0, 1'b0);

        run_mix(200);
        drain();
        cfg_node(7'd127);
        run_mix(420);
        drain();
        cfg_node(7'($urandom_range(2, 126)));
        run_mix(640);
        drain();
        cfg_node(7'd1);
        calm = 1'b1;
        run_mix(850);
        drain();

        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
